/* src/ipdh_pkg.sv */
// ----------------------------------------------------------------------------
// ipdh_pkg
// Shared constants, types and a helper function for the IPv4 dedup hash set.
// ----------------------------------------------------------------------------
package ipdh_pkg;

    localparam int SLOTS      = 4096;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = 13;
    localparam int ADDR_W     = 32;
    localparam int PFX_W      = 6;
    localparam int STATUS_W   = 2;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    localparam logic [STATUS_W-1:0] ST_NEW  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input beat, start hash
        logic hash_step;  // one fnv byte
        logic rd;         // issue table read at probe index
        logic advance;    // step probe index
        logic wr;         // insert key at probe index
        logic clr;        // clear sweep write
        logic out_load;   // capture result
        logic [STATUS_W-1:0] status;
    } ipdh_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic slot_valid;
        logic slot_match;
        logic probes_done;
        logic clr_done;
    } ipdh_sts_t;

    function automatic logic [31:0] fnv_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

/* src/ipdh_datapath.sv */
// ----------------------------------------------------------------------------
// ipdh_datapath
// Key masking, FNV-1a hash, two slot tables with valid bits held in memory,
// probe index and counters.
// ----------------------------------------------------------------------------
module ipdh_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ipdh_pkg::ipdh_cmd_t             cmd,
    output ipdh_pkg::ipdh_sts_t             sts,
    input  logic [ipdh_pkg::ADDR_W-1:0]     in_address,
    input  logic [ipdh_pkg::PFX_W-1:0]      in_prefix_len,
    input  logic                            in_is_range,
    output logic [ipdh_pkg::STATUS_W-1:0]   res_status,
    output logic [ipdh_pkg::ADDR_W-1:0]     res_address,
    output logic [ipdh_pkg::CNT_W-1:0]      res_count
);
    localparam int IW = ipdh_pkg::IDX_W;

    logic [31:0]    addr_reg, addr_next;
    logic [5:0]     pfx_reg, pfx_next;
    logic           rng_reg;
    logic [31:0]    hash_reg, hash_next;
    logic [2:0]     hcnt_reg;
    logic [IW-1:0]  idx_reg;
    logic [IW:0]    probe_reg;
    logic [IW:0]    clr_reg;
    logic [12:0]    scnt_reg, rcnt_reg;
    logic [12:0]    cur_cnt;

    // slot word: valid, address, prefix
    logic [38:0]    single_mem [ipdh_pkg::SLOTS];
    logic [38:0]    range_mem  [ipdh_pkg::SLOTS];
    logic [38:0]    rd_single_reg, rd_range_reg, rd_word;
    logic [38:0]    wr_word;
    logic [IW-1:0]  wr_idx;

    always_comb begin
        logic [5:0] p;
        p = (in_prefix_len > 6'd32) ? 6'd32 : in_prefix_len;
        pfx_next  = in_is_range ? p : 6'd0;
        addr_next = in_address;
        if (in_is_range) begin
            addr_next = (p == 6'd0) ? 32'd0 : (in_address & (ipdh_pkg::ALL_ONES << (6'd32 - p)));
        end
    end

    always_comb begin
        logic [7:0] b;
        case (hcnt_reg)
            3'd0:    b = addr_reg[31:24];
            3'd1:    b = addr_reg[23:16];
            3'd2:    b = addr_reg[15:8];
            3'd3:    b = addr_reg[7:0];
            default: b = {2'd0, pfx_reg};
        endcase
        hash_next = ipdh_pkg::fnv_byte(hash_reg, b);
    end

    assign rd_word = rng_reg ? rd_range_reg : rd_single_reg;
    assign cur_cnt = rng_reg ? rcnt_reg : scnt_reg;
    assign wr_word = cmd.clr ? 39'd0 : {1'b1, addr_reg, pfx_reg};
    assign wr_idx  = cmd.clr ? clr_reg[IW-1:0] : idx_reg;

    assign sts.hash_done   = rng_reg ? (hcnt_reg == 3'd5) : (hcnt_reg == 3'd4);
    assign sts.slot_valid  = rd_word[38];
    assign sts.slot_match  = (rd_word[37:6] == addr_reg) && (rd_word[5:0] == pfx_reg);
    assign sts.probes_done = (probe_reg == (IW+1)'(ipdh_pkg::SLOTS));
    assign sts.clr_done    = (clr_reg == (IW+1)'(ipdh_pkg::SLOTS));

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_single_reg <= single_mem[idx_reg];
            rd_range_reg  <= range_mem[idx_reg];
        end
        if ((cmd.wr && !rng_reg) || cmd.clr) begin
            single_mem[wr_idx] <= wr_word;
        end
        if ((cmd.wr && rng_reg) || cmd.clr) begin
            range_mem[wr_idx] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= addr_next;
            pfx_reg  <= pfx_next;
            rng_reg  <= in_is_range;
            hash_reg <= ipdh_pkg::FNV_OFFSET;
        end else if (cmd.hash_step) begin
            hash_reg <= hash_next;
        end
        if (cmd.out_load) begin
            res_status  <= cmd.status;
            res_address <= addr_reg;
            res_count   <= (cmd.status == ipdh_pkg::ST_NEW) ? cur_cnt + 13'd1 : cur_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hcnt_reg  <= 3'd0;
            idx_reg   <= '0;
            probe_reg <= '0;
            clr_reg   <= '0;
            scnt_reg  <= 13'd0;
            rcnt_reg  <= 13'd0;
        end else begin
            if (cmd.clr) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load) begin
                hcnt_reg  <= 3'd0;
                probe_reg <= '0;
            end else if (cmd.hash_step) begin
                hcnt_reg <= hcnt_reg + 3'd1;
                // slot index from final hash once the last byte is folded in
                idx_reg  <= hash_next[IW-1:0];
            end
            if (cmd.advance) begin
                idx_reg   <= idx_reg + 1'b1;
                probe_reg <= probe_reg + 1'b1;
            end
            if (cmd.wr && !rng_reg) begin
                scnt_reg <= scnt_reg + 13'd1;
            end
            if (cmd.wr && rng_reg) begin
                rcnt_reg <= rcnt_reg + 13'd1;
            end
        end
    end
endmodule

/* src/ipdh_ctrl.sv */
// ----------------------------------------------------------------------------
// ipdh_ctrl
// Sequencer: clear sweep, hash, probe walk, result handoff.
// ----------------------------------------------------------------------------
module ipdh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ipdh_pkg::ipdh_cmd_t cmd,
    input  ipdh_pkg::ipdh_sts_t sts
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       oval_reg, oval_next;

    assign out_valid = oval_reg;
    // new beat only when the result register is free to take its answer
    assign in_ready  = (state_reg == S_IDLE) && (!oval_reg || out_ready);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        oval_next  = oval_reg && !out_ready;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.clr = 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (sts.hash_done) begin
                    state_next = S_READ;
                end else begin
                    cmd.hash_step = 1'b1;
                end
            end
            S_READ: begin
                if (sts.probes_done) begin
                    cmd.status   = ipdh_pkg::ST_FULL;
                    cmd.out_load = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!sts.slot_valid) begin
                    cmd.status   = ipdh_pkg::ST_NEW;
                    cmd.wr       = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_DONE;
                end else if (sts.slot_match) begin
                    cmd.status   = ipdh_pkg::ST_DUP;
                    cmd.out_load = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE: begin
                oval_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end
endmodule

/* src/ipv4_dedup_hash_set_top.sv */
// ----------------------------------------------------------------------------
// ipv4_dedup_hash_set_top
// IPv4 address / CIDR range deduplicator over two FNV-1a probed hash tables.
// ----------------------------------------------------------------------------
// After reset the block sweeps both 4096-slot tables clear, one slot a cycle,
// before it takes a beat. An item then hashes four bytes (singles) or five
// (ranges) and walks the probe loop, which visits each probed slot in a read
// state and a check state, set by the synchronous read of the slot memory;
// status full is returned once all 4096 slots have been probed without a hit.
module ipv4_dedup_hash_set_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[31:0], prefix_len[37:32], zero pad
    input  logic        s_tuser,   // is_range
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], stored_address[33:2], set_count[46:34], pad
);
    ipdh_pkg::ipdh_cmd_t cmd;
    ipdh_pkg::ipdh_sts_t sts;
    logic [1:0]  r_status;
    logic [31:0] r_addr;
    logic [12:0] r_count;

    ipdh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ipdh_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_address    (s_tdata[31:0]),
        .in_prefix_len (s_tdata[37:32]),
        .in_is_range   (s_tuser),
        .res_status    (r_status),
        .res_address   (r_addr),
        .res_count     (r_count)
    );

    assign m_tdata = {1'b0, r_count, r_addr, r_status};
endmodule
